>>> rtl/core/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, clocked on clk, off during rst
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/tga_rle_pkg.sv
package tga_rle_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH,
    CFG_IMAGE_HEIGHT,
    CFG_FOUR_BYTE
  } cfg_reg_t;

  // header bytes below this open a literal packet
  localparam logic [7:0] LITERAL_LIMIT = 8'd128;
  // run length is header minus this
  localparam logic [7:0] RUN_BIAS      = 8'd127;

  // one completed pixel with the work it causes
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] fit;
    logic       overrun;
    logic       done;
  } job_t;

endpackage

>>> rtl/core/tga_rle_byte_if.sv
interface tga_rle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

>>> rtl/core/tga_rle_pix_if.sv
interface tga_rle_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_a;
  logic [7:0] green_a;
  logic [7:0] blue_a;
  logic [7:0] alpha_a;
  logic [7:0] red_b;
  logic [7:0] green_b;
  logic [7:0] blue_b;
  logic [7:0] alpha_b;
  logic [1:0] pixels_carried;
  logic       last_of_run;
  logic       image_done;
  logic       overrun_error;

  modport source (
    output valid, input ready,
    output red_a, green_a, blue_a, alpha_a, red_b, green_b, blue_b, alpha_b,
    output pixels_carried, last_of_run, image_done, overrun_error
  );
  modport sink (
    input valid, output ready,
    input red_a, green_a, blue_a, alpha_a, red_b, green_b, blue_b, alpha_b,
    input pixels_carried, last_of_run, image_done, overrun_error
  );
endinterface

>>> rtl/core/tga_rle_front.sv
module tga_rle_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        pixel_count,
  input  logic               four_byte_pixels,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  logic [7:0]         byte_in,
  input  logic               queue_full,
  output logic               push,
  output tga_rle_pkg::job_t  job
);

  logic [31:0] pixels_written, pixels_written_next;
  logic [7:0]  packet_left, packet_left_next;
  logic        packet_is_run, packet_is_run_next;
  logic        awaiting_header, awaiting_header_next;
  logic [1:0]  byte_slot, byte_slot_next;
  logic [23:0] pixel_bytes, pixel_bytes_next;
  logic        finished, finished_next;
  logic        failed, failed_next;

  logic        accept;
  logic        pixel_complete;
  logic [7:0]  n;
  logic [31:0] remaining;
  logic        short_fit;
  logic [7:0]  fit;
  logic        done_hit;

  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;

  assign pixel_complete = four_byte_pixels ? (byte_slot == 2'd3) : (byte_slot >= 2'd2);

  // pixels this byte would emit
  always_comb begin
    n = packet_is_run ? packet_left : 8'd1;
    if (n == 8'd0) begin
      n = 8'd1;
    end
  end

  // a smaller image written mid-stream leaves no room
  assign remaining = (pixels_written >= pixel_count) ? 32'd0 : pixel_count - pixels_written;
  assign short_fit = remaining < {24'd0, n};
  assign fit       = short_fit ? remaining[7:0] : n;
  // fit never exceeds remaining, so equality means the image is now full
  assign done_hit  = (remaining[31:8] == 24'd0) && (remaining[7:0] == fit);

  always_comb begin
    job.red     = four_byte_pixels ? pixel_bytes[23:16] : byte_in;
    job.green   = pixel_bytes[15:8];
    job.blue    = pixel_bytes[7:0];
    job.alpha   = four_byte_pixels ? byte_in : 8'd0;
    job.fit     = fit;
    job.overrun = short_fit;
    job.done    = 1'b0;
    if (!short_fit && (packet_left <= n) && done_hit) begin
      job.done = 1'b1;
    end
  end

  assign push = accept && !finished && !failed && !awaiting_header && pixel_complete;

  always_comb begin
    pixels_written_next  = pixels_written;
    packet_left_next     = packet_left;
    packet_is_run_next   = packet_is_run;
    awaiting_header_next = awaiting_header;
    byte_slot_next       = byte_slot;
    pixel_bytes_next     = pixel_bytes;
    finished_next        = finished;
    failed_next          = failed;
    if (accept && !finished && !failed) begin
      if (awaiting_header) begin
        if (byte_in < tga_rle_pkg::LITERAL_LIMIT) begin
          packet_is_run_next = 1'b0;
          packet_left_next   = byte_in + 8'd1;
        end else begin
          packet_is_run_next = 1'b1;
          packet_left_next   = byte_in - tga_rle_pkg::RUN_BIAS;
        end
        awaiting_header_next = 1'b0;
        byte_slot_next       = 2'd0;
      end else if (!pixel_complete) begin
        case (byte_slot)
          2'd0:    pixel_bytes_next[7:0]   = byte_in;
          2'd1:    pixel_bytes_next[15:8]  = byte_in;
          default: pixel_bytes_next[23:16] = byte_in;
        endcase
        byte_slot_next = byte_slot + 2'd1;
      end else begin
        byte_slot_next      = 2'd0;
        pixels_written_next = pixels_written + {24'd0, fit};
        if (short_fit) begin
          failed_next = 1'b1;
        end else begin
          packet_left_next = (packet_left >= n) ? packet_left - n : 8'd0;
          if (packet_left <= n) begin
            awaiting_header_next = 1'b1;
            finished_next        = done_hit;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_written  <= '0;
      packet_left     <= '0;
      packet_is_run   <= 1'b0;
      awaiting_header <= 1'b1;
      byte_slot       <= '0;
      pixel_bytes     <= '0;
      finished        <= 1'b0;
      failed          <= 1'b0;
    end else begin
      pixels_written  <= pixels_written_next;
      packet_left     <= packet_left_next;
      packet_is_run   <= packet_is_run_next;
      awaiting_header <= awaiting_header_next;
      byte_slot       <= byte_slot_next;
      pixel_bytes     <= pixel_bytes_next;
      finished        <= finished_next;
      failed          <= failed_next;
    end
  end

endmodule

>>> rtl/core/tga_rle_queue.sv
module tga_rle_queue #(
  parameter int DEPTH = tga_rle_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tga_rle_pkg::job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output tga_rle_pkg::job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tga_rle_pkg::job_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> rtl/core/tga_rle_back.sv
module tga_rle_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              queue_empty,
  input  tga_rle_pkg::job_t head,
  output logic              pop,
  tga_rle_pix_if.source     pixels
);

  logic              active;
  tga_rle_pkg::job_t cur;
  logic [7:0]        left;
  logic              out_valid;
  logic              advance;
  logic [1:0]        carry;
  logic              last;

  assign advance = !out_valid || pixels.ready;

  always_comb begin
    if (cur.fit == 8'd0) begin
      carry = 2'd0;
    end else if (left >= 8'd2) begin
      carry = 2'd2;
    end else begin
      carry = 2'd1;
    end
  end

  assign last = (left <= 8'd2);
  // take the next job when idle or when the current one sends its final result
  assign pop  = !queue_empty && (!active || (advance && last));

  assign pixels.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
      end else if (active && advance && last) begin
        active <= 1'b0;
      end
      if (advance) begin
        out_valid <= active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= head;
      left <= head.fit;
    end else if (active && advance) begin
      left <= left - {6'd0, carry};
    end
    if (active && advance) begin
      pixels.red_a          <= (carry != 2'd0) ? cur.red : 8'd0;
      pixels.green_a        <= (carry != 2'd0) ? cur.green : 8'd0;
      pixels.blue_a         <= (carry != 2'd0) ? cur.blue : 8'd0;
      pixels.alpha_a        <= (carry != 2'd0) ? cur.alpha : 8'd0;
      pixels.red_b          <= (carry == 2'd2) ? cur.red : 8'd0;
      pixels.green_b        <= (carry == 2'd2) ? cur.green : 8'd0;
      pixels.blue_b         <= (carry == 2'd2) ? cur.blue : 8'd0;
      pixels.alpha_b        <= (carry == 2'd2) ? cur.alpha : 8'd0;
      pixels.pixels_carried <= carry;
      pixels.last_of_run    <= last;
      pixels.image_done     <= last && cur.done;
      pixels.overrun_error  <= last && cur.overrun;
    end
  end

endmodule

>>> rtl/core/tga_rle_pixel_decoder.sv
// channel   | dir | handshake       | payload
// bytes     | in  | valid / ready   | byte_in
// pixels    | out | valid / ready   | red/green/blue/alpha a and b, count, flags
// cfg       | in  | cfg_we          | cfg_index, cfg_data
//
// header bytes and bytes inside a pixel emit nothing
// the byte that completes a pixel queues one job; the back end then emits
// one result per cycle while the pixel sink is ready, ceil(fit/2) results per job (one if no pixel fits)
// bytes stall only while the job queue (QUEUE_DEPTH entries) is full
// synchronous reset clears all control state
// the pixel count product is registered on the same edge as the size write
module tga_rle_pixel_decoder #(
  parameter int QUEUE_DEPTH = tga_rle_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tga_rle_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_data,
  tga_rle_byte_if.sink                       bytes,
  tga_rle_pix_if.source                      pixels
);

  logic [15:0]       image_width;
  logic [15:0]       image_height;
  logic              four_byte_pixels;
  logic [15:0]       size_w;
  logic [15:0]       size_h;
  logic [31:0]       pixel_count;
  logic              queue_full;
  logic              queue_empty;
  logic              push;
  logic              pop;
  tga_rle_pkg::job_t push_job;
  tga_rle_pkg::job_t head;

  // sizes as they stand after this write
  assign size_w = (cfg_index == tga_rle_pkg::CFG_IMAGE_WIDTH) ? cfg_data : image_width;
  assign size_h = (cfg_index == tga_rle_pkg::CFG_IMAGE_HEIGHT) ? cfg_data : image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= 16'd1;
      image_height     <= 16'd1;
      four_byte_pixels <= 1'b0;
      pixel_count      <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        tga_rle_pkg::CFG_IMAGE_WIDTH:  image_width      <= cfg_data;
        tga_rle_pkg::CFG_IMAGE_HEIGHT: image_height     <= cfg_data;
        tga_rle_pkg::CFG_FOUR_BYTE:    four_byte_pixels <= cfg_data[0];
        default: ;
      endcase
      pixel_count <= {16'd0, size_w} * {16'd0, size_h};
    end
  end

  tga_rle_front u_front (
    .clk              (clk),
    .rst              (rst),
    .pixel_count      (pixel_count),
    .four_byte_pixels (four_byte_pixels),
    .byte_valid       (bytes.valid),
    .byte_ready       (bytes.ready),
    .byte_in          (bytes.byte_in),
    .queue_full       (queue_full),
    .push             (push),
    .job              (push_job)
  );

  tga_rle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .head     (head)
  );

  tga_rle_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head        (head),
    .pop         (pop),
    .pixels      (pixels)
  );

endmodule

>>> rtl/core/tga_rle_checker.sv
`include "assert_macros.svh"

module tga_rle_checker (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic [7:0] red_b,
  input logic [7:0] green_b,
  input logic [7:0] blue_b,
  input logic [7:0] alpha_b,
  input logic [1:0] pixels_carried,
  input logic       last_of_run,
  input logic       image_done,
  input logic       overrun_error
);

  // a request waiting on the sink is not withdrawn
  `ASSERT_NEXT(a_valid_holds, valid && !ready, valid)
  `ASSERT_IMPLY(a_carried_range, valid, pixels_carried != 2'd3)
  // a request with no pixel only reports an overrun and closes the byte
  `ASSERT_IMPLY(a_error_only, valid && (pixels_carried == 2'd0), overrun_error && last_of_run)
  `ASSERT_IMPLY(a_done_final, valid && image_done, last_of_run && !overrun_error)
  `ASSERT_IMPLY(a_second_zero, valid && !pixels_carried[1], ~|{red_b, green_b, blue_b, alpha_b})

endmodule

bind tga_rle_pixel_decoder tga_rle_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .valid          (pixels.valid),
  .ready          (pixels.ready),
  .red_b          (pixels.red_b),
  .green_b        (pixels.green_b),
  .blue_b         (pixels.blue_b),
  .alpha_b        (pixels.alpha_b),
  .pixels_carried (pixels.pixels_carried),
  .last_of_run    (pixels.last_of_run),
  .image_done     (pixels.image_done),
  .overrun_error  (pixels.overrun_error)
);

>>> bench/tga_rle_pixel_decoder_test.sv
`timescale 1ns / 100ps

module tga_rle_pixel_decoder_test;

  localparam int RANDOM_ITEMS = 128;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] red_a;
    logic [7:0] green_a;
    logic [7:0] blue_a;
    logic [7:0] alpha_a;
    logic [7:0] red_b;
    logic [7:0] green_b;
    logic [7:0] blue_b;
    logic [7:0] alpha_b;
    logic [1:0] pixels_carried;
    logic       last_of_run;
    logic       image_done;
    logic       overrun_error;
  } px_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [tga_rle_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [tga_rle_pkg::CFG_DATA_W-1:0] cfg_data;

  tga_rle_byte_if byte_ch ();
  tga_rle_pix_if pix_ch ();

  tga_rle_pixel_decoder i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .bytes(byte_ch),
    .pixels(pix_ch)
  );

  // decoder state as the testbench sees it
  logic [15:0] cfg_w = 16'd1;
  logic [15:0] cfg_h = 16'd1;
  logic        cfg_quad = 1'b0;
  logic [31:0] px_done = '0;
  logic [31:0] pkt_left = '0;
  logic        pkt_run = 1'b0;
  logic        want_header = 1'b1;
  logic [1:0]  slot = '0;
  logic [23:0] held = '0;
  logic        img_done = 1'b0;
  logic        img_failed = 1'b0;

  px_result_t due_results[$];
  int faults = 0;
  int bytes_sent = 0;
  int stall_left = 0;
  logic calm = 1'b0;
  logic hold_active;
  event hold_go;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic string show_result(input px_result_t r);
    return $sformatf({"a=%02h/%02h/%02h/%02h b=%02h/%02h/%02h/%02h ",
                      "n=%0d last=%0b done=%0b ovr=%0b"},
                     r.red_a, r.green_a, r.blue_a, r.alpha_a,
                     r.red_b, r.green_b, r.blue_b, r.alpha_b,
                     r.pixels_carried, r.last_of_run, r.image_done, r.overrun_error);
  endfunction

  // expected pixel results for one accepted byte
  function automatic void decode_byte(input logic [7:0] b);
    logic [7:0] red, green, blue, alpha;
    logic [31:0] n, fit, room, total;
    logic overrun;
    int k, j, left;
    px_result_t res;
    if (img_done || img_failed) return;
    if (want_header) begin
      pkt_run = (b >= tga_rle_pkg::LITERAL_LIMIT);
      pkt_left = pkt_run ? 32'(b) - 32'(tga_rle_pkg::RUN_BIAS) : 32'(b) + 32'd1;
      want_header = 1'b0;
      slot = '0;
      return;
    end
    if (slot < (cfg_quad ? 3 : 2)) begin
      held[8*slot +: 8] = b;
      slot = slot + 1'b1;
      return;
    end
    // a late size switch completes the pixel on whatever slot it reached
    blue = held[7:0];
    green = held[15:8];
    red = cfg_quad ? held[23:16] : b;
    alpha = cfg_quad ? b : 8'd0;
    slot = '0;
    n = pkt_run ? pkt_left : 32'd1;
    if (n == 0) n = 32'd1;
    total = cfg_w * cfg_h;
    room = (px_done >= total) ? 32'd0 : total - px_done;
    fit = (n < room) ? n : room;
    overrun = (fit < n);
    px_done = px_done + fit;
    if (overrun) begin
      img_failed = 1'b1;
    end else begin
      pkt_left = (pkt_left >= n) ? pkt_left - n : 32'd0;
      // completion only counts at a packet end
      if (pkt_left == 0) begin
        want_header = 1'b1;
        img_done = (px_done == total);
      end
    end
    k = (fit == 0) ? 1 : int'((fit + 32'd1) / 32'd2);
    for (j = 0; j < k; j++) begin
      res = '0;
      left = int'(fit) - 2 * j;
      if (left >= 1) begin
        res.red_a = red;
        res.green_a = green;
        res.blue_a = blue;
        res.alpha_a = alpha;
      end
      if (left >= 2) begin
        res.red_b = red;
        res.green_b = green;
        res.blue_b = blue;
        res.alpha_b = alpha;
      end
      res.pixels_carried = (left >= 2) ? 2'd2 : left[1:0];
      if (j == k - 1) begin
        res.last_of_run = 1'b1;
        res.image_done = img_done;
        res.overrun_error = overrun;
      end
      due_results.push_back(res);
    end
  endfunction

  always @(posedge clk) begin : check_pixels
    px_result_t seen, want;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      seen.red_a = pix_ch.red_a;
      seen.green_a = pix_ch.green_a;
      seen.blue_a = pix_ch.blue_a;
      seen.alpha_a = pix_ch.alpha_a;
      seen.red_b = pix_ch.red_b;
      seen.green_b = pix_ch.green_b;
      seen.blue_b = pix_ch.blue_b;
      seen.alpha_b = pix_ch.alpha_b;
      seen.pixels_carried = pix_ch.pixels_carried;
      seen.last_of_run = pix_ch.last_of_run;
      seen.image_done = pix_ch.image_done;
      seen.overrun_error = pix_ch.overrun_error;
      if (due_results.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected pixel result %s", show_result(seen));
      end else begin
        want = due_results.pop_front();
        if (seen !== want) begin
          faults++;
          if (faults <= 10) begin
            $display("pixel result mismatch: expected %s", show_result(want));
            $display("                       actual   %s", show_result(seen));
          end
        end
      end
    end
  end

  // output side: random stall bursts, none once calm, nothing while held off
  always @(posedge clk) begin
    if (rst || hold_active) begin
      pix_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      pix_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 13);
      pix_ch.ready <= 1'b0;
    end else begin
      pix_ch.ready <= 1'b1;
    end
  end

  initial begin : receiver_hold
    hold_active = 1'b0;
    forever begin
      @(hold_go);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  // valid stays high after a request so back-to-back bytes need no toggle
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.byte_in <= b;
    do @(posedge clk); while (!byte_ch.ready);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic send_pixel();
    repeat (cfg_quad ? 4 : 3) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    // header and partial-pixel bytes leave no result to wait for
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] w, input logic [15:0] h, input logic quad);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= tga_rle_pkg::CFG_IMAGE_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= tga_rle_pkg::CFG_IMAGE_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_index <= tga_rle_pkg::CFG_FOUR_BYTE;
    cfg_data <= {{(tga_rle_pkg::CFG_DATA_W-1){1'b0}}, quad};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_w = w;
    cfg_h = h;
    cfg_quad = quad;
  endtask

  // mostly well-formed packets with random content, some stray bytes
  task automatic send_packets(input int budget);
    int start, kind, pixels, i;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      kind = $urandom_range(0, 9);
      if (kind == 0 || !want_header) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (kind <= 5) begin
        if ($urandom_range(0, 1)) send_byte(8'(tga_rle_pkg::RUN_BIAS + $urandom_range(1, 8)));
        else send_byte(8'(tga_rle_pkg::RUN_BIAS + $urandom_range(1, 128)));
        send_pixel();
      end else begin
        pixels = $urandom_range(1, 6);
        send_byte(8'(pixels - 1));
        for (i = 0; i < pixels; i++) send_pixel();
      end
    end
  endtask

  task automatic test_literal_packets();
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'h01);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
  endtask

  task automatic test_run_packets();
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    // longest run, 64 results
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
  endtask

  task automatic test_pixel_size_switch();
    send_byte(8'h00);
    send_byte(8'hA1);
    send_byte(8'hB2);
    write_config(16'hFFFF, 16'hFFFF, 1'b1);
    send_byte(8'hC3);
    send_byte(8'hD4);
    send_byte(8'h83);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    write_config(16'hFFFF, 16'hFFFF, 1'b0);
    send_byte(8'h44);
  endtask

  task automatic test_output_stall();
    int p;
    write_config(16'hFFFF, 16'hFFFF, 1'($urandom_range(0, 1)));
    -> hold_go;
    for (p = 0; p < 8; p++) begin
      send_byte(8'hFF);
      send_pixel();
    end
  endtask

  task automatic test_random_stream();
    int phase;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_config(16'hFFFF, 16'hFFFF, 1'($urandom_range(0, 1)));
        1: write_config(16'd1, 16'hFFFF, 1'($urandom_range(0, 1)));
        2: write_config(16'hFFFF, 16'd1, 1'($urandom_range(0, 1)));
        default: begin
          calm = 1'b1;
          write_config(16'($urandom_range(256, 65535)), 16'($urandom_range(256, 65535)),
                       1'($urandom_range(0, 1)));
        end
      endcase
      send_packets(RANDOM_ITEMS / 4);
    end
  endtask

  // one terminal event per run: exact completion, overrun in a run,
  // or the image filling up inside a literal packet
  task automatic test_image_end();
    int ending, fit_n, run_n;
    logic [15:0] total;
    while (!want_header) send_byte(8'($urandom_range(0, 255)));
    ending = $urandom_range(0, 2);
    fit_n = (ending == 0) ? $urandom_range(1, 128) :
            (ending == 1) ? $urandom_range(0, 64) : 1;
    total = 16'(px_done + 32'(fit_n));
    if ($urandom_range(0, 1)) write_config(16'd1, total, 1'($urandom_range(0, 1)));
    else write_config(total, 16'd1, 1'($urandom_range(0, 1)));
    case (ending)
      0: begin
        send_byte(8'(int'(tga_rle_pkg::RUN_BIAS) + fit_n));
        send_pixel();
      end
      1: begin
        run_n = fit_n + $urandom_range(1, 128 - fit_n);
        send_byte(8'(int'(tga_rle_pkg::RUN_BIAS) + run_n));
        send_pixel();
      end
      default: begin
        send_byte(8'h01);
        send_pixel();
        send_pixel();
      end
    endcase
    // decoder is finished now, these are dropped
    repeat (6) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= tga_rle_pkg::CFG_IMAGE_WIDTH;
    cfg_data <= '0;
    byte_ch.valid <= 1'b0;
    byte_ch.byte_in <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_config(16'hFFFF, 16'hFFFF, 1'b0);
    test_literal_packets();
    test_run_packets();
    test_pixel_size_switch();
    test_output_stall();
    test_random_stream();
    test_image_end();
    drain();
    if (faults == 0 && due_results.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/tga_rle_pkg.sv
rtl/core/tga_rle_byte_if.sv
rtl/core/tga_rle_pix_if.sv
rtl/core/tga_rle_front.sv
rtl/core/tga_rle_queue.sv
rtl/core/tga_rle_back.sv
rtl/core/tga_rle_pixel_decoder.sv
rtl/core/tga_rle_checker.sv
bench/tga_rle_pixel_decoder_test.sv
